/* hdl/reliable_retransmit_queue_unit_macros.svh */
`ifndef RELIABLE_RETRANSMIT_QUEUE_UNIT_MACROS_SVH
`define RELIABLE_RETRANSMIT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define RRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rrq_pkg.sv */
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int unsigned NumConnDef   = 16;
  localparam int unsigned NumChanDef   = 4;
  localparam int unsigned RingSlotsDef = 16;

  localparam logic [15:0] NoBuffer      = 16'hFFFF;
  localparam logic [31:0] TimeoutReset  = 32'd200;
  localparam int unsigned InTdataW      = 144;
  localparam int unsigned OutTdataW     = 40;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_RESEND = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESEND  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PTR_RD,
    ST_PTR_WAIT,
    ST_REC,
    ST_WALK_CHK,
    ST_WALK_EVAL,
    ST_WALK_END
  } state_e;

  typedef struct packed {
    logic load_item;
    logic ptr_rd;
    logic ptr_latch;
    logic rec_exec;
    logic ent_rd;
    logic eval_step;
    logic ring_wr;
    logic chan_next;
    logic finish_push;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    usable;
    logic    conn_ok;
    logic    at_tail;
    logic    eval_go;
    logic    eval_break;
    logic    out_free;
    logic    last_chan;
    logic    pend_valid;
  } sts_t;

endpackage

/* hdl/rrq_ctrl.sv */
`timescale 1ns / 1ps

module rrq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrq_pkg::sts_t sts_i,
  output rrq_pkg::cmd_t cmd_o
);
  import rrq_pkg::*;

  state_e state_q, state_d;
  logic   finish_q, finish_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      finish_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      finish_q <= finish_d;
    end
  end

  // finish_q marks the closing push, taken from the idle state
  always_comb begin
    state_d  = state_q;
    finish_d = finish_q;
    unique case (state_q)
      ST_IDLE: begin
        if (finish_q) begin
          if (sts_i.out_free) finish_d = 1'b0;
        end else if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.action == ACT_CLEAR) begin
          if (sts_i.conn_ok) state_d = ST_PTR_RD;
          else begin
            state_d  = ST_IDLE;
            finish_d = 1'b1;
          end
        end else if (sts_i.usable) begin
          state_d = ST_PTR_RD;
        end else if (sts_i.action == ACT_RECORD) begin
          state_d = ST_REC;
        end else begin
          state_d  = ST_IDLE;
          finish_d = 1'b1;
        end
      end
      ST_PTR_RD:   state_d = ST_PTR_WAIT;
      ST_PTR_WAIT: state_d = (sts_i.action == ACT_RECORD) ? ST_REC : ST_WALK_CHK;
      ST_REC: begin
        state_d  = ST_IDLE;
        finish_d = 1'b1;
      end
      ST_WALK_CHK: state_d = sts_i.at_tail ? ST_WALK_END : ST_WALK_EVAL;
      ST_WALK_EVAL: begin
        if (sts_i.eval_break) state_d = ST_WALK_END;
        else if (sts_i.eval_go) state_d = ST_WALK_CHK;
      end
      ST_WALK_END: begin
        if (sts_i.action == ACT_CLEAR && !sts_i.last_chan) state_d = ST_PTR_RD;
        else begin
          state_d  = ST_IDLE;
          finish_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o          = !finish_q;
        cmd_o.load_item     = !finish_q && in_valid_i;
        cmd_o.finish_push   = finish_q && sts_i.out_free;
      end
      ST_DECODE:    ;
      ST_PTR_RD:    cmd_o.ptr_rd = 1'b1;
      ST_PTR_WAIT:  cmd_o.ptr_latch = 1'b1;
      ST_REC:       cmd_o.rec_exec = 1'b1;
      ST_WALK_CHK:  cmd_o.ent_rd = !sts_i.at_tail;
      ST_WALK_EVAL: cmd_o.eval_step = sts_i.eval_go && !sts_i.eval_break;
      ST_WALK_END: begin
        cmd_o.ring_wr   = 1'b1;
        cmd_o.chan_next = (sts_i.action == ACT_CLEAR) && !sts_i.last_chan;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/rrq_datapath.sv */
`timescale 1ns / 1ps

module rrq_datapath #(
  parameter int unsigned NUM_CONN   = rrq_pkg::NumConnDef,
  parameter int unsigned NUM_CHAN   = rrq_pkg::NumChanDef,
  parameter int unsigned RING_SLOTS = rrq_pkg::RingSlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrq_pkg::cmd_t                  cmd_i,
  output rrq_pkg::sts_t                  sts_o,
  input  logic [1:0]                     in_tuser_i,
  input  logic [rrq_pkg::InTdataW-1:0]   in_tdata_i,
  input  logic                           cfg_we_i,
  input  logic [31:0]                    cfg_wdata_i,
  output logic                           out_tvalid_o,
  input  logic                           out_tready_i,
  output logic [1:0]                     out_tuser_o,
  output logic [rrq_pkg::OutTdataW-1:0]  out_tdata_o,
  output logic                           out_tlast_o
);
  import rrq_pkg::*;

  localparam int unsigned Rings   = NUM_CONN * NUM_CHAN;
  localparam int unsigned Entries = Rings * RING_SLOTS;
  localparam int unsigned PtrMod  = 2 * RING_SLOTS;
  localparam int unsigned PW      = $clog2(PtrMod);
  localparam int unsigned RW      = (Rings > 1) ? $clog2(Rings) : 1;
  localparam int unsigned EW      = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CHW     = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;

  typedef struct packed {
    logic        vld;
    logic [15:0] buffer;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [15:0] buffer;
    logic [15:0] len;
    logic [3:0]  conn;
  } res_t;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(PtrMod - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] p);
    slot_of = (p >= PW'(RING_SLOTS)) ? p - PW'(RING_SLOTS) : p;
  endfunction

  action_e        action_q;
  logic [3:0]     conn_q;
  logic [CHW-1:0] chan_q;
  logic           usable_q, conn_ok_q;
  logic [15:0]    seq_q, buf_q, len_q, ack_q;
  logic [31:0]    now_q, mask_q, timeout_q;
  logic [4:0]     room_q, n_q;
  logic [PW-1:0]  head_q, tail_q, p_q, nhead_q;
  logic           found_q;
  res_t           pend_q, out_q, push_res;
  logic           pend_valid_q, out_valid_q, out_last_q;

  logic [2*PW-1:0] ptr_mem [Rings];
  logic [Rings-1:0] ptr_vld_q;
  logic [2*PW-1:0] ptr_rd_q;
  logic            ptr_rd_vld_q;
  entry_t          ent_mem [Entries];
  entry_t          ent_q, ent_wd;

  logic [RW-1:0]   ring_idx;
  logic [EW-1:0]   ent_addr;
  logic            ptr_we, ent_we, rec_ok, hit, acked, aged, out_free, push, push_last;
  logic [2*PW-1:0] ptr_wd;
  logic [PW:0]     used;
  logic [15:0]     seq_gap;
  logic [31:0]     age;
  logic            in_conn_ok, in_usable;

  assign in_conn_ok = 32'(in_tdata_i[3:0]) < NUM_CONN;
  assign in_usable  = in_conn_ok && in_tdata_i[7] && in_tdata_i[6]
                      && (32'(in_tdata_i[5:4]) < NUM_CHAN);

  assign ring_idx = RW'(32'(conn_q) * NUM_CHAN + 32'(chan_q));
  assign ent_addr = EW'(32'(ring_idx) * RING_SLOTS
                        + 32'(slot_of(cmd_i.rec_exec ? tail_q : p_q)));

  assign used = (tail_q >= head_q) ? {1'b0, tail_q} - {1'b0, head_q}
              : {1'b0, tail_q} + (PW + 1)'(PtrMod) - {1'b0, head_q};
  assign rec_ok = usable_q && (buf_q != NoBuffer) && (used < (PW + 1)'(RING_SLOTS));

  assign seq_gap = ack_q - ent_q.seq;
  assign acked = (seq_gap == 16'd0)
              || ((seq_gap <= 16'd32) && mask_q[5'(seq_gap - 16'd1)]);
  assign age   = now_q - ent_q.stamp;
  assign aged  = age >= timeout_q;

  always_comb begin
    case (action_q)
      ACT_ACK:    hit = ent_q.vld && acked;
      ACT_RESEND: hit = ent_q.vld && aged;
      ACT_CLEAR:  hit = ent_q.vld;
      default:    hit = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || out_tready_i;

  always_comb begin
    ent_wd = ent_q;
    if (cmd_i.rec_exec) begin
      ent_wd = '{vld: 1'b1, buffer: buf_q, seq: seq_q, stamp: now_q, len: len_q};
    end else if (action_q == ACT_RESEND) begin
      ent_wd.stamp = now_q;
    end else begin
      ent_wd.vld = 1'b0;
      ent_wd.len = '0;
    end
  end
  assign ent_we = (cmd_i.rec_exec && rec_ok) || (cmd_i.eval_step && hit);

  always_comb begin
    if (cmd_i.rec_exec) ptr_wd = {head_q, next_ptr(tail_q)};
    else if (action_q == ACT_ACK) ptr_wd = {found_q ? nhead_q : tail_q, tail_q};
    else ptr_wd = {tail_q, tail_q};
  end
  assign ptr_we = (cmd_i.rec_exec && rec_ok)
               || (cmd_i.ring_wr && (action_q != ACT_RESEND));

  assign push      = cmd_i.finish_push || (cmd_i.eval_step && hit && pend_valid_q);
  assign push_last = cmd_i.finish_push;
  always_comb begin
    push_res = pend_q;
    if (cmd_i.finish_push && !pend_valid_q) push_res = '{KIND_NONE, 1'b0, 16'd0, 16'd0, 4'd0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_rd) ptr_rd_q <= ptr_mem[ring_idx];
    if (ptr_we) ptr_mem[ring_idx] <= ptr_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) ent_q <= ent_mem[ent_addr];
    if (ent_we) ent_mem[ent_addr] <= ent_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_e'(in_tuser_i);
      conn_q   <= in_tdata_i[3:0];
      chan_q   <= (action_e'(in_tuser_i) == ACT_CLEAR) ? '0 : CHW'(in_tdata_i[5:4]);
      usable_q <= in_usable;
      conn_ok_q <= in_conn_ok;
      seq_q    <= in_tdata_i[23:8];
      buf_q    <= in_tdata_i[39:24];
      len_q    <= in_tdata_i[55:40];
      now_q    <= in_tdata_i[87:56];
      ack_q    <= in_tdata_i[103:88];
      mask_q   <= in_tdata_i[135:104];
      room_q   <= in_tdata_i[140:136];
      n_q      <= '0;
    end else begin
      if (cmd_i.chan_next) chan_q <= chan_q + CHW'(1);
      if (cmd_i.eval_step && hit) n_q <= n_q + 5'd1;
    end
    if (cmd_i.ptr_latch) begin
      head_q  <= ptr_rd_vld_q ? ptr_rd_q[2*PW-1:PW] : '0;
      tail_q  <= ptr_rd_vld_q ? ptr_rd_q[PW-1:0] : '0;
      p_q     <= ptr_rd_vld_q ? ptr_rd_q[2*PW-1:PW] : '0;
      found_q <= 1'b0;
    end else if (cmd_i.eval_step) begin
      p_q <= next_ptr(p_q);
      if (!hit && ent_q.vld && !found_q) begin
        nhead_q <= p_q;
        found_q <= 1'b1;
      end
    end
    if (cmd_i.rec_exec) pend_q <= '{KIND_RECORD, rec_ok, 16'd0, 16'd0, 4'd0};
    else if (cmd_i.eval_step && hit) begin
      pend_q <= '{(action_q == ACT_RESEND) ? KIND_RESEND : KIND_RELEASE, 1'b0,
                  ent_q.buffer, (action_q == ACT_RESEND) ? ent_q.len : 16'd0, conn_q};
    end
    if (push) begin
      out_q      <= push_res;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_vld_q    <= '0;
      ptr_rd_vld_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= TimeoutReset;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (ptr_we) ptr_vld_q[ring_idx] <= 1'b1;
      if (cmd_i.ptr_rd) ptr_rd_vld_q <= ptr_vld_q[ring_idx];
      if (cmd_i.finish_push) pend_valid_q <= 1'b0;
      else if (cmd_i.rec_exec || (cmd_i.eval_step && hit)) pend_valid_q <= 1'b1;
      if (push) out_valid_q <= 1'b1;
      else if (out_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.action     = action_q;
  assign sts_o.usable     = usable_q;
  assign sts_o.conn_ok    = conn_ok_q;
  assign sts_o.at_tail    = (p_q == tail_q);
  assign sts_o.eval_go    = !hit || !pend_valid_q || out_free;
  assign sts_o.eval_break = (action_q == ACT_RESEND) && hit && (n_q >= room_q);
  assign sts_o.out_free   = out_free;
  assign sts_o.last_chan  = (chan_q == CHW'(NUM_CHAN - 1));
  assign sts_o.pend_valid = pend_valid_q;

  assign out_tvalid_o = out_valid_q;
  assign out_tuser_o  = out_q.kind;
  assign out_tdata_o  = {3'b000, out_q.conn, out_q.len, out_q.buffer, out_q.ok};
  assign out_tlast_o  = out_last_q;

endmodule

/* hdl/reliable_retransmit_queue_unit.sv */
// Retransmit queue: one ring of unacknowledged packets per connection and
// reliable channel. Each input beat on the s_axis channel (action in tuser)
// records a packet, processes an ack, runs a resend pass or clears a
// connection. Results leave on m_axis (kind in tuser); tlast marks the final
// result beat of each input beat, and an action with no other result gives
// one beat of kind "nothing more".
// Ack and resend walk one ring; clear walks the ring of each channel of the
// connection in turn. The walk is set by the single-port entry memory: each
// entry is read and, if it changes, written back before the next is read.
// One input beat is in work at a time; the next is accepted the cycle after
// the last result is registered. A stalled m_axis receiver holds the output
// register and the walk pauses at the next result. Reset empties every
// ring at once (per-ring valid bits); there is no clearing pass.
// resend_timeout_ms resets to 200. The user writes it by cfg_we_i and
// cfg_wdata_i only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "reliable_retransmit_queue_unit_macros.svh"

module reliable_retransmit_queue_unit #(
  parameter int unsigned NUM_CONN   = rrq_pkg::NumConnDef,
  parameter int unsigned NUM_CHAN   = rrq_pkg::NumChanDef,
  parameter int unsigned RING_SLOTS = rrq_pkg::RingSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action
  input  logic [1:0]                    s_axis_tuser,
  // conn_id, chan_index, chan_reliable, conn_alive, seq_num, buffer_index,
  // packet_len, now_time, ack_num, ack_mask, out_room
  input  logic [rrq_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // kind
  output logic [1:0]                    m_axis_tuser,
  // ok, out_buffer, out_len, out_conn
  output logic [rrq_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import rrq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrq_datapath #(
    .NUM_CONN   (NUM_CONN),
    .NUM_CHAN   (NUM_CHAN),
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tuser_i   (s_axis_tuser),
    .in_tdata_i   (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tuser_o  (m_axis_tuser),
    .out_tdata_o  (m_axis_tdata),
    .out_tlast_o  (m_axis_tlast)
  );

  `RRQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a beat while busy")
  `RRQ_ASSERT_NOW(a_idle_no_pending, s_axis_tready, !sts.pend_valid, "pending result left at idle")
  `RRQ_ASSERT_NOW(a_record_is_last, m_axis_tvalid && (m_axis_tuser == KIND_RECORD), m_axis_tlast, "record reply not last")

endmodule

/* verif/retransmit_checker.sv */
`timescale 1ns / 1ps

module retransmit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,
  input  logic [rrq_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [1:0]                    m_axis_tuser,
  input  logic [rrq_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                          m_axis_tlast,
  output int                            fail_count_o,
  output int                            pending_o
);
  import rrq_pkg::*;

  localparam int NConn = NumConnDef;
  localparam int NChan = NumChanDef;
  localparam int Slots = RingSlotsDef;
  localparam int PtrMod = 2 * Slots;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [15:0] buffer;
    logic [15:0] len;
    logic [3:0]  conn;
    logic        last;
  } result_t;

  result_t     pending_results[$];
  logic [31:0] timeout_ms;
  int          head_ptr[NConn*NChan];
  int          tail_ptr[NConn*NChan];
  logic        slot_live[NConn*NChan*Slots];
  logic [15:0] slot_buffer[NConn*NChan*Slots];
  logic [15:0] slot_seq[NConn*NChan*Slots];
  logic [31:0] slot_time[NConn*NChan*Slots];
  logic [15:0] slot_len[NConn*NChan*Slots];

  assign pending_o = pending_results.size();

  function automatic logic ack_covers(logic [15:0] seq, logic [15:0] ack, logic [31:0] mask);
    logic [15:0] d;
    d = ack - seq;
    if (d == 0) return 1'b1;
    if (d <= 32) return mask[d-1];
    return 1'b0;
  endfunction

  task automatic push_result(kind_e k, logic ok, logic [15:0] b, logic [15:0] l,
                             logic [3:0] c);
    result_t r;
    r.kind = k; r.ok = ok; r.buffer = b; r.len = l; r.conn = c; r.last = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic predict_beat(action_e act, logic [InTdataW-1:0] d);
    logic [3:0]  conn;
    logic [1:0]  chan;
    logic        reliable, alive, usable;
    logic [15:0] seq, buf_idx, len, ack;
    logic [31:0] now, mask;
    logic [4:0]  room;
    int          ring, e, p, h, t, n, r;
    conn = d[3:0]; chan = d[5:4]; reliable = d[6]; alive = d[7];
    seq = d[23:8]; buf_idx = d[39:24]; len = d[55:40]; now = d[87:56];
    ack = d[103:88]; mask = d[135:104]; room = d[140:136];
    usable = alive && reliable && conn < NConn && chan < NChan;
    ring = usable ? conn * NChan + chan : 0;
    n = 0;
    case (act)
      ACT_RECORD: begin
        logic ok;
        ok = 1'b0;
        if (usable && buf_idx != NoBuffer &&
            (tail_ptr[ring] - head_ptr[ring] + PtrMod) % PtrMod < Slots) begin
          e = ring * Slots + tail_ptr[ring] % Slots;
          slot_live[e] = 1'b1; slot_buffer[e] = buf_idx; slot_seq[e] = seq;
          slot_time[e] = now; slot_len[e] = len;
          tail_ptr[ring] = (tail_ptr[ring] + 1) % PtrMod;
          ok = 1'b1;
        end
        push_result(KIND_RECORD, ok, 0, 0, 0);
        n++;
      end
      ACT_ACK: if (usable) begin
        h = head_ptr[ring]; t = tail_ptr[ring];
        for (p = h; p != t; p = (p + 1) % PtrMod) begin
          e = ring * Slots + p % Slots;
          if (slot_live[e] && ack_covers(slot_seq[e], ack, mask)) begin
            push_result(KIND_RELEASE, 0, slot_buffer[e], 0, conn);
            n++;
            slot_live[e] = 1'b0;
          end
        end
        while (h != t && !slot_live[ring * Slots + h % Slots]) h = (h + 1) % PtrMod;
        head_ptr[ring] = h;
      end
      ACT_RESEND: if (usable) begin
        t = tail_ptr[ring];
        for (p = head_ptr[ring]; p != t; p = (p + 1) % PtrMod) begin
          e = ring * Slots + p % Slots;
          if (slot_live[e] && (now - slot_time[e]) >= timeout_ms) begin
            if (n >= room) break;
            push_result(KIND_RESEND, 0, slot_buffer[e], slot_len[e], conn);
            n++;
            slot_time[e] = now;
          end
        end
      end
      default: if (conn < NConn) begin
        for (int c = 0; c < NChan; c++) begin
          r = conn * NChan + c;
          t = tail_ptr[r];
          for (p = head_ptr[r]; p != t; p = (p + 1) % PtrMod) begin
            e = r * Slots + p % Slots;
            if (slot_live[e]) begin
              push_result(KIND_RELEASE, 0, slot_buffer[e], 0, conn);
              n++;
              slot_live[e] = 1'b0;
            end
          end
          head_ptr[r] = t;
        end
      end
    endcase
    if (n == 0) push_result(KIND_NONE, 0, 0, 0, 0);
    pending_results[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r, got;
    if (!rst_ni) begin
      timeout_ms <= TimeoutReset;
      for (int i = 0; i < NConn * NChan; i++) begin
        head_ptr[i] = 0;
        tail_ptr[i] = 0;
      end
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      pending_results.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) timeout_ms <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.ok = m_axis_tdata[0];
        got.buffer = m_axis_tdata[16:1];
        got.len = m_axis_tdata[32:17];
        got.conn = m_axis_tdata[36:33];
        got.last = m_axis_tlast;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = pending_results.pop_front();
          if (got !== exp_r || m_axis_tdata[39:37] !== 3'b0) begin
            $display("%0t: result mismatch, expected %h, got %h (tdata %h)",
                     $time, exp_r, got, m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_beat(action_e'(s_axis_tuser), s_axis_tdata);
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rrq_pkg::*;

  localparam int IdleLimit = 20000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [1:0]            s_axis_tuser;
  logic [InTdataW-1:0]   s_axis_tdata;
  logic                  cfg_we_i;
  logic [31:0]           cfg_wdata_i;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [1:0]            m_axis_tuser;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles;
  logic                  stall_enable;
  logic [31:0]           clock_ms;
  logic [15:0]           next_seq[4][4];
  logic [15:0]           acked_seq[4][4];

  reliable_retransmit_queue_unit DUT (.*);

  retransmit_checker checker_inst (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .cfg_we_i, .cfg_wdata_i, .m_axis_tvalid, .m_axis_tready, .m_axis_tuser,
    .m_axis_tdata, .m_axis_tlast, .fail_count_o(fail_count),
    .pending_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // drain side: random stall per result beat
  initial begin
    int wait_cycles;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        wait_cycles = stall_enable ? $urandom_range(0, 16) : 0;
        if (wait_cycles > 0 && !m_axis_tready) begin
          repeat (wait_cycles - 1) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end else if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles - 1) @(posedge clk_i);
          @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(action_e act, logic [3:0] conn, logic [1:0] chan,
                           logic reliable, logic alive, logic [15:0] seq,
                           logic [15:0] buf_idx, logic [15:0] len, logic [31:0] now,
                           logic [15:0] ack, logic [31:0] mask, logic [4:0] room);
    int gap;
    gap = stall_enable ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {3'b0, room, mask, ack, now, len, buf_idx, seq, alive, reliable,
                     chan, conn};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_timeout(logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed traffic on a few connections, some noise
  task automatic random_beat();
    int          pick;
    logic [3:0]  conn;
    logic [1:0]  chan;
    logic        good;
    pick = $urandom_range(0, 99);
    conn = $urandom_range(0, 3);
    chan = $urandom_range(0, 3);
    good = $urandom_range(0, 9) != 0;
    if ($urandom_range(0, 19) == 0) conn = $urandom_range(0, 15);
    clock_ms = clock_ms + $urandom_range(0, 120);
    if (pick < 45) begin
      send_beat(ACT_RECORD, conn, chan, good || $urandom_range(0, 1), good ||
                $urandom_range(0, 1), next_seq[conn%4][chan],
                ($urandom_range(0, 30) == 0) ? NoBuffer : 16'($urandom()),
                16'($urandom()), clock_ms, 0, 0, 0);
      next_seq[conn%4][chan] = next_seq[conn%4][chan] + 1;
    end else if (pick < 75) begin
      acked_seq[conn%4][chan] = next_seq[conn%4][chan] - 16'($urandom_range(0, 6));
      send_beat(ACT_ACK, conn, chan, good, 1'b1, 16'($urandom()), 16'($urandom()),
                16'($urandom()), clock_ms, acked_seq[conn%4][chan],
                ($urandom_range(0, 9) == 0) ? 32'($urandom()) :
                32'($urandom()) & 32'hFF, 0);
    end else if (pick < 95) begin
      send_beat(ACT_RESEND, conn, chan, good, good, 16'($urandom()), 16'($urandom()),
                16'($urandom()), clock_ms, 0, 0, 5'($urandom_range(0, 16)));
    end else begin
      send_beat(ACT_CLEAR, conn, chan, 1'($urandom()), 1'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()), clock_ms, 0, 0, 0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    stall_enable = 1'b1;
    clock_ms = 32'd1000;
    foreach (next_seq[i, j]) begin
      next_seq[i][j] = 16'hFFF0;
      acked_seq[i][j] = 16'hFFF0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, fill a ring, wrap acks, mask edges, resend room, clear
    send_beat(ACT_RECORD, 0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 0);
    send_beat(ACT_RECORD, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0);
    send_beat(ACT_RECORD, 0, 0, 1, 1, 1, NoBuffer, 1, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_beat(ACT_RECORD, 15, 3, 1, 1, 16'(16'hFFF8 + i), 16'(i), 16'hFFFF - 16'(i),
                32'hFFFF_FFF0, 0, 0, 0);
    send_beat(ACT_RESEND, 15, 3, 1, 1, 0, 0, 0, 32'h0000_0100, 0, 0, 5'd3);
    send_beat(ACT_RESEND, 15, 3, 1, 1, 0, 0, 0, 32'h0000_0100, 0, 0, 5'd16);
    send_beat(ACT_ACK, 15, 3, 1, 1, 0, 0, 0, 0, 16'h0007, 32'h8000_0001, 0);
    send_beat(ACT_ACK, 15, 3, 0, 1, 0, 0, 0, 0, 16'h0007, 32'hFFFF_FFFF, 0);
    send_beat(ACT_ACK, 15, 3, 1, 1, 0, 0, 0, 0, 16'hFFF9, 32'h0000_0001, 0);
    send_beat(ACT_CLEAR, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(ACT_CLEAR, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(ACT_RESEND, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0);

    write_timeout(32'd1);
    for (int i = 0; i < 100; i++) random_beat();
    write_timeout(32'hFFFF_FFFF);
    stall_enable = 1'b0;
    for (int i = 0; i < 60; i++) random_beat();
    stall_enable = 1'b1;
    write_timeout(32'd150);
    for (int i = 0; i < 160; i++) random_beat();

    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rrq_pkg.sv
hdl/rrq_ctrl.sv
hdl/rrq_datapath.sv
hdl/reliable_retransmit_queue_unit.sv
verif/retransmit_checker.sv
verif/testbench.sv
